// ----- hw/rtl/tnve_pkg.sv -----
// tnve_pkg: shared types and constants for the tagged number varint encoder
// no dependencies
package tnve_pkg;

   localparam int unsigned REG_WIDTH = 54;
   localparam logic [REG_WIDTH-1:0] LIMIT_CAP = 54'h20_0000_0000_0000;
   localparam logic [REG_WIDTH-1:0] LIMIT_RESET = 54'h1F_FFFF_FFFF_FFFF;

   localparam logic [7:0] TAG_NAN     = 8'hA5;
   localparam logic [7:0] TAG_POS_INF = 8'hA6;
   localparam logic [7:0] TAG_NEG_INF = 8'hA7;
   localparam logic [7:0] TAG_POS_INT = 8'hA8;
   localparam logic [7:0] TAG_NEG_INT = 8'hA9;
   localparam logic [7:0] TAG_RAW     = 8'hAA;
   localparam logic [7:0] NEG_SHORT_BASE = 8'h80;

   localparam logic [0:0] REG_UPPER = 1'b0;
   localparam logic [0:0] REG_LOWER = 1'b1;

   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_VARINT = 2'd1,
      KIND_RAW    = 2'd2
   } kind_type;

   // one classified item handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  head;     // first byte of the encoding
      logic [63:0] payload;  // varint value or raw pattern
   } job_type;

endpackage

// ----- hw/rtl/tnve_front.sv -----
// tnve_front: classifies one binary64 pattern into a job for the byte emitter
// depends on tnve_pkg
module tnve_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [63:0]                    value_bits,
   input  logic [tnve_pkg::REG_WIDTH-1:0] upper_limit,
   input  logic [tnve_pkg::REG_WIDTH-1:0] lower_mag,
   output logic                           job_valid,
   input  logic                           job_ready,
   output tnve_pkg::job_type              job
);

   logic              valid_ff, valid_in;
   tnve_pkg::job_type job_ff, job_in;

   logic        neg;
   logic [10:0] ex;
   logic [51:0] man;
   logic [52:0] full;
   logic [5:0]  sh;
   logic [52:0] frac_mask;
   logic        integral;
   logic [53:0] mag;
   logic [53:0] up_cap, lo_cap;

   always_comb begin
      neg  = value_bits[63];
      ex   = value_bits[62:52];
      man  = value_bits[51:0];
      full = {1'b1, man};
      sh   = 6'd0;
      frac_mask = '0;
      integral = 1'b0;
      mag = '0;
      if (ex == 11'd0) begin
         integral = (man == 52'd0);
      end else if (ex == 11'd1076) begin
         integral = 1'b1;
         mag = {full, 1'b0};
      end else if (ex >= 11'd1023 && ex < 11'd1076) begin
         // shift count 52 - e, e in 0..52
         sh = 6'(11'd1075 - ex);
         frac_mask = (53'd1 << sh) - 53'd1;
         integral = ((full & frac_mask) == 53'd0);
         mag = {1'b0, full >> sh};
      end
      up_cap = (upper_limit > tnve_pkg::LIMIT_CAP) ? tnve_pkg::LIMIT_CAP : upper_limit;
      lo_cap = (lower_mag > tnve_pkg::LIMIT_CAP) ? tnve_pkg::LIMIT_CAP : lower_mag;

      job_in.kind    = tnve_pkg::KIND_RAW;
      job_in.head    = tnve_pkg::TAG_RAW;
      job_in.payload = value_bits;
      if (ex == 11'h7FF) begin
         job_in.kind = tnve_pkg::KIND_SINGLE;
         if (man != 52'd0) begin
            job_in.head = tnve_pkg::TAG_NAN;
         end else begin
            job_in.head = neg ? tnve_pkg::TAG_NEG_INF : tnve_pkg::TAG_POS_INF;
         end
      end else if (integral && !neg && mag <= up_cap) begin
         if (mag < 54'd128) begin
            job_in.kind = tnve_pkg::KIND_SINGLE;
            job_in.head = mag[7:0];
         end else begin
            job_in.kind    = tnve_pkg::KIND_VARINT;
            job_in.head    = tnve_pkg::TAG_POS_INT;
            job_in.payload = {10'd0, mag - 54'd128};
         end
      end else if (integral && neg && mag <= lo_cap) begin
         if (mag < 54'd32) begin
            job_in.kind = tnve_pkg::KIND_SINGLE;
            job_in.head = tnve_pkg::NEG_SHORT_BASE + mag[7:0];
         end else begin
            job_in.kind    = tnve_pkg::KIND_VARINT;
            job_in.head    = tnve_pkg::TAG_NEG_INT;
            job_in.payload = {10'd0, mag - 54'd32};
         end
      end
   end

   assign in_ready = !valid_ff || job_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

// ----- hw/rtl/tnve_queue.sv -----
// tnve_queue: two-entry job queue between classifier and emitter
// depends on tnve_pkg
module tnve_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  tnve_pkg::job_type wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output tnve_pkg::job_type rd_job
);

   tnve_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;
   assign rd_job = slot_ff[rd_ptr_ff];
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ----- hw/rtl/tnve_back.sv -----
// tnve_back: walks one job out as a byte stream with a last marker
// depends on tnve_pkg
module tnve_back #(
   parameter int unsigned MAX_VARINT_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  tnve_pkg::job_type job,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              out_last
);

   localparam int unsigned CW = 4;

   // busy: head sent, emitting body bytes
   logic              busy_ff, busy_in;
   tnve_pkg::kind_type kind_ff, kind_in;
   logic [63:0]       data_ff, data_in;
   logic [CW-1:0]     cnt_ff, cnt_in;   // body bytes emitted so far
   logic              take;
   logic              fire;
   logic              body_last;

   assign fire = out_valid && out_ready;

   always_comb begin
      body_last = 1'b0;
      if (kind_ff == tnve_pkg::KIND_RAW) begin
         body_last = (cnt_ff == CW'(7));
      end else begin
         body_last = (data_ff < 64'd128) || (cnt_ff == CW'(MAX_VARINT_BYTES - 1));
      end
      if (busy_ff) begin
         out_valid = 1'b1;
         out_last  = body_last;
         if (kind_ff == tnve_pkg::KIND_RAW) begin
            out_byte = data_ff[7:0];
         end else begin
            out_byte = {!body_last, data_ff[6:0]};
         end
      end else begin
         out_valid = job_valid;
         out_last  = (job.kind == tnve_pkg::KIND_SINGLE);
         out_byte  = job.head;
      end
   end

   assign job_ready = !busy_ff && out_ready;
   assign take = job_valid && job_ready;

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (take) begin
         busy_in = (job.kind != tnve_pkg::KIND_SINGLE);
         kind_in = job.kind;
         data_in = job.payload;
         cnt_in  = '0;
      end else if (busy_ff && fire) begin
         busy_in = !body_last;
         cnt_in  = cnt_ff + CW'(1);
         data_in = (kind_ff == tnve_pkg::KIND_RAW) ? (data_ff >> 8) : (data_ff >> 7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      kind_ff <= kind_in;
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ----- hw/rtl/tagged_number_varint_encoder.sv -----
// tagged_number_varint_encoder: top level of the tagged number encoder
// depends on tnve_pkg, tnve_front, tnve_queue, tnve_back
//
// takes one binary64 bit pattern per req transfer and sends its tagged byte
// encoding on rsp, one byte per transfer, with tlast on the final byte.
// infinities and nan give one tag byte, integral values inside the limits a
// short byte or a tag plus a varint, everything else 0xaa plus eight raw
// bytes. the emitter sends one byte per cycle while rsp_tready is high, and an
// item takes 1 to 9 bytes on the rsp side while the classifier and a two-entry
// job queue keep accepting new numbers. the limit registers are written over
// csr: index 0 upper limit, index 1 lower magnitude; other indexes ignored.
module tagged_number_varint_encoder #(
   parameter int unsigned MAX_VARINT_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input numbers
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value_bits
   // encoded bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // last_byte
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [tnve_pkg::REG_WIDTH-1:0] upper_ff, lower_ff;

   // limit registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= tnve_pkg::LIMIT_RESET;
         lower_ff <= tnve_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tnve_pkg::REG_UPPER: upper_ff <= csr_data[tnve_pkg::REG_WIDTH-1:0];
            tnve_pkg::REG_LOWER: lower_ff <= csr_data[tnve_pkg::REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic              f_valid, f_ready, q_valid, q_ready;
   tnve_pkg::job_type f_job, q_job;

   // front: classify and register
   tnve_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .value_bits  (req_tdata),
      .upper_limit (upper_ff),
      .lower_mag   (lower_ff),
      .job_valid   (f_valid),
      .job_ready   (f_ready),
      .job         (f_job)
   );

   // decoupling queue
   tnve_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_job   (f_job),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_job   (q_job)
   );

   // back: byte emitter
   tnve_back #(
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for the tagged number varint encoder
// depends on tnve_pkg and tagged_number_varint_encoder; predicts each byte string
// from the bit pattern and checks rsp transfers in order under random back-pressure
module testbench;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } enc_byte_type;

   typedef struct {
      logic [63:0] bits;
      int          nbytes;     // 0 means predictor only
      logic [7:0]  b0;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // value_bits
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // out_byte
   logic        rsp_tlast;   // last_byte
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [63:0] csr_data;

   // predictor copy of the limit registers
   logic [tnve_pkg::REG_WIDTH-1:0] upper_limit;
   logic [tnve_pkg::REG_WIDTH-1:0] lower_mag;

   enc_byte_type expected_bytes[$];
   int          mismatch_count;
   int          bytes_checked;
   int          items_sent;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_cycles;   // long receiver hold-off, counted in rsp process

   tagged_number_varint_encoder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle counter doubles as watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [tnve_pkg::REG_WIDTH-1:0] capped(
      input logic [tnve_pkg::REG_WIDTH-1:0] r);
      return (r > tnve_pkg::LIMIT_CAP) ? tnve_pkg::LIMIT_CAP : r;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      enc_byte_type e;
      e.data = b;
      e.last = 1'b0;
      expected_bytes.push_back(e);
   endfunction

   function automatic void push_varint(input logic [63:0] v);
      int n;
      n = 1;
      while (v >= 128 && n < 8) begin
         push_byte({1'b1, v[6:0]});
         v = v >> 7;
         n++;
      end
      push_byte({1'b0, v[6:0]});
   endfunction

   // expected encoding of one number, appended to the byte queue
   function automatic void encode_number(input logic [63:0] bits);
      logic        neg;
      logic [10:0] ex;
      logic [51:0] man;
      logic [63:0] full;
      logic [63:0] mag;
      logic        integral;
      int          e;
      int          sh;
      neg = bits[63];
      ex = bits[62:52];
      man = bits[51:0];
      integral = 1'b0;
      mag = '0;
      if (ex == 11'h7ff) begin
         if (man != 0) push_byte(tnve_pkg::TAG_NAN);
         else push_byte(neg ? tnve_pkg::TAG_NEG_INF : tnve_pkg::TAG_POS_INF);
      end else begin
         if (ex == 0) begin
            if (man == 0) integral = 1'b1;
         end else if (ex >= 1023 && ex <= 1076) begin
            e = ex - 1023;
            full = {11'd0, 1'b1, man};
            if (e == 53) begin
               integral = 1'b1;
               mag = full << 1;
            end else begin
               sh = 52 - e;
               if ((full & ((64'd1 << sh) - 1)) == 0) begin
                  integral = 1'b1;
                  mag = full >> sh;
               end
            end
         end
         if (integral && !neg && mag <= {10'd0, capped(upper_limit)}) begin
            if (mag < 128) push_byte(mag[7:0]);
            else begin
               push_byte(tnve_pkg::TAG_POS_INT);
               push_varint(mag - 128);
            end
         end else if (integral && neg && mag <= {10'd0, capped(lower_mag)}) begin
            if (mag < 32) push_byte(tnve_pkg::NEG_SHORT_BASE + mag[7:0]);
            else begin
               push_byte(tnve_pkg::TAG_NEG_INT);
               push_varint(mag - 32);
            end
         end else begin
            push_byte(tnve_pkg::TAG_RAW);
            for (int i = 0; i < 8; i++) push_byte(bits[8*i +: 8]);
         end
      end
      expected_bytes[$].last = 1'b1;
   endfunction

   // random integral double of magnitude below 2^bits_wide
   function automatic logic [63:0] make_integral(input int bits_wide, input logic neg);
      logic [63:0] m;
      logic [63:0] r;
      int          top;
      m = {$urandom, $urandom} & ((64'd1 << bits_wide) - 1);
      if (m == 0) return {neg, 63'd0};
      top = 63;
      while (!m[top]) top--;
      r = m << (52 - top);
      if (top > 52) r = m >> (top - 52);
      return {neg, 11'(1023 + top), r[51:0]};
   endfunction

   // double with exact magnitude (below 2^53)
   function automatic logic [63:0] exact_double(input logic [63:0] m, input logic neg);
      int top;
      if (m == 0) return {neg, 63'd0};
      top = 63;
      while (!m[top]) top--;
      return {neg, 11'(1023 + top), 52'((m << (52 - top)))};
   endfunction

   function automatic logic [63:0] random_number();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return make_integral($urandom_range(1, 8), 1'($urandom_range(0, 1)));
      if (pick < 55) return make_integral($urandom_range(1, 54), 1'($urandom_range(0, 1)));
      if (pick < 62) return {1'($urandom_range(0, 1)), 11'h7ff,
                             ($urandom_range(0, 2) == 0) ? 52'd0 : 52'({$urandom, $urandom})};
      if (pick < 72) return {1'($urandom_range(0, 1)), 11'(1023 + $urandom_range(0, 70)),
                             52'({$urandom, $urandom})};
      return {$urandom, $urandom};
   endfunction

   task automatic write_limit(input logic [0:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == tnve_pkg::REG_UPPER) upper_limit = value[tnve_pkg::REG_WIDTH-1:0];
      else lower_mag = value[tnve_pkg::REG_WIDTH-1:0];
      @(negedge clock);
   endtask

   // valid stays up after a transfer; the next call or drain decides what follows
   task automatic send_number(input logic [63:0] bits);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= bits;
      encode_number(bits);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // wait for the byte queue to drain, then settle before a register write
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // result side: random stall, long hold when asked, check each transfer
   always @(posedge clock) begin
      enc_byte_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked <= bytes_checked + 1;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected byte %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            e = expected_bytes.pop_front();
            if (e.data !== rsp_tdata || e.last !== rsp_tlast) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("byte mismatch: expected %h/%b got %h/%b",
                           e.data, e.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   stim_row_type directed_rows[$];

   initial begin
      logic [63:0] big;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = tnve_pkg::REG_UPPER;
      csr_data = '0;
      reset = 1'b1;
      items_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      upper_limit = tnve_pkg::LIMIT_RESET;
      lower_mag = tnve_pkg::LIMIT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: single-byte rows carry their byte, others use the predictor
      directed_rows = '{
         '{64'h7ff0_0000_0000_0000, 1, tnve_pkg::TAG_POS_INF},
         '{64'hfff0_0000_0000_0000, 1, tnve_pkg::TAG_NEG_INF},
         '{64'h7ff8_0000_0000_0000, 1, tnve_pkg::TAG_NAN},
         '{64'hffff_ffff_ffff_ffff, 1, tnve_pkg::TAG_NAN},
         '{64'h7ff0_0000_0000_0001, 1, tnve_pkg::TAG_NAN},
         '{64'h0000_0000_0000_0000, 1, 8'h00},       // zero
         '{64'h8000_0000_0000_0000, 1, 8'h80},       // negative zero
         '{64'h405f_c000_0000_0000, 1, 8'h7f},       // 127
         '{64'h4060_0000_0000_0000, 0, 8'h00},       // 128
         '{64'hc03f_0000_0000_0000, 1, 8'h9f},       // -31
         '{64'hc040_0000_0000_0000, 0, 8'h00},       // -32
         '{64'h433f_ffff_ffff_ffff, 0, 8'h00},       // 2^53-1
         '{64'h4340_0000_0000_0000, 0, 8'h00},       // 2^53 beyond default
         '{64'hc33f_ffff_ffff_ffff, 0, 8'h00},
         '{64'h3ff8_0000_0000_0000, 0, 8'h00},       // fraction 1.5
         '{64'h0000_0000_0000_0001, 0, 8'h00},       // subnormal
         '{64'h7fef_ffff_ffff_ffff, 0, 8'h00},       // largest finite
         '{64'h3fe0_0000_0000_0000, 0, 8'h00}        // 0.5
      };
      foreach (directed_rows[i]) begin
         send_number(directed_rows[i].bits);
         if (directed_rows[i].nbytes == 1 && expected_bytes[$].data !== directed_rows[i].b0) begin
            mismatch_count++;
            $display("table row %0d predicts %h, table says %h",
                     i, expected_bytes[$].data, directed_rows[i].b0);
         end
      end
      drain();

      // limits at 2^53 and above: cap applies, 2^53 becomes integer
      write_limit(tnve_pkg::REG_UPPER, 64'h003f_ffff_ffff_ffff);
      write_limit(tnve_pkg::REG_LOWER, 64'h0020_0000_0000_0000);
      send_number(64'h4340_0000_0000_0000);
      send_number(64'hc340_0000_0000_0000);
      send_number(64'h4340_0000_0000_0001);
      drain();

      // zero limits: everything but zero goes raw
      write_limit(tnve_pkg::REG_UPPER, 64'd0);
      write_limit(tnve_pkg::REG_LOWER, 64'd0);
      send_number(64'h0);
      send_number(64'h8000_0000_0000_0000);
      send_number(64'h3ff0_0000_0000_0000);
      send_number(64'hbff0_0000_0000_0000);
      drain();

      // random phases with several limit settings and idle mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               write_limit(tnve_pkg::REG_UPPER, 64'(tnve_pkg::LIMIT_RESET));
               write_limit(tnve_pkg::REG_LOWER, 64'(tnve_pkg::LIMIT_RESET));
            end
            1: begin
               send_idle_pct = 53; recv_stall_pct = 0;
               write_limit(tnve_pkg::REG_UPPER,
                           {$urandom, $urandom} & 64'h3f_ffff_ffff_ffff);
               write_limit(tnve_pkg::REG_LOWER, 64'(1000));
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 53;
               write_limit(tnve_pkg::REG_UPPER, 64'(200));
               write_limit(tnve_pkg::REG_LOWER, {$urandom, $urandom} & 64'h1f_ffff_ffff);
            end
            default: begin
               send_idle_pct = 23; recv_stall_pct = 23;
               write_limit(tnve_pkg::REG_UPPER, 64'(tnve_pkg::LIMIT_CAP));
               write_limit(tnve_pkg::REG_LOWER, 64'h3f_ffff_ffff_ffff);
            end
         endcase
         for (int n = 0; n < 62; n++) begin
            // near-limit values
            if (n % 9 == 0) begin
               big = {10'd0, capped(upper_limit)} + $urandom_range(0, 2) - 1;
               send_number(exact_double(big & 64'h1f_ffff_ffff_ffff, 1'b0));
            end else send_number(random_number());
         end
         drain();
      end

      // long receiver hold-off so the block fills and stalls req
      hold_cycles = 200;
      send_idle_pct = 0;
      for (int n = 0; n < 12; n++) send_number(random_number());
      drain();

      $display("sent %0d numbers, checked %0d bytes across limit settings and idle mixes",
               items_sent, bytes_checked);
      if (mismatch_count == 0 && expected_bytes.size() == 0) $display("CHECK OK");
      else begin
         $display("%0d mismatches, %0d bytes missing", mismatch_count, expected_bytes.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- tagged_number_varint_encoder.f -----
hw/rtl/tnve_pkg.sv
hw/rtl/tnve_front.sv
hw/rtl/tnve_queue.sv
hw/rtl/tnve_back.sv
hw/rtl/tagged_number_varint_encoder.sv
verif/testbench.sv
